### design/cswq_pkg.sv
// Shared types and constants for the counting semaphore wait queue.
// Used by cswq_ctrl, cswq_dp and counting_semaphore_wait_queue.
package cswq_pkg;

   localparam int NUM_THREADS    = 16;
   localparam int NUM_SEMAPHORES = 8;

   localparam int THREAD_W = 4;
   localparam int SEM_W    = 3;
   localparam int OP_W     = 2;
   localparam int COUNT_W  = 16;
   localparam int INIT_W   = 15;

   localparam int REQ_FIELDS_W = OP_W + SEM_W + THREAD_W;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + 1 + THREAD_W + COUNT_W + 1;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_WAIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
   localparam logic [OP_W-1:0] OP_RELOAD = 2'd2;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
   localparam logic [INIT_W-1:0]         INIT_RESET = 15'd1;

   typedef logic [THREAD_W-1:0]        thread_type;
   typedef logic [SEM_W-1:0]           sem_type;
   typedef logic signed [COUNT_W-1:0]  count_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic capture;   // latch the request transaction
      logic execute;   // read-modify-write tables, load response
   } cmd_type;

endpackage

### design/cswq_ctrl.sv
// Controller for the semaphore wait queue: sequences capture and execute,
// owns the request/response handshakes. Depends on cswq_pkg.
module cswq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output cswq_pkg::cmd_type cmd
);
   import cswq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // accept only when the response slot is free by the end of the next cycle
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/cswq_dp.sv
// Datapath for the semaphore wait queue: count bank, list head/tail
// tables, next-waiter links, reload register and response register.
// Depends on cswq_pkg.
module cswq_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  cswq_pkg::cmd_type           cmd,
   input  logic [cswq_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        csr_valid,
   input  logic [cswq_pkg::INIT_W-1:0] csr_data,
   output logic [cswq_pkg::RSP_W-1:0]  rsp_tdata
);
   import cswq_pkg::*;

   logic [OP_W-1:0] opcode_ff;
   sem_type         sem_ff;
   thread_type      thread_ff;
   logic [INIT_W-1:0] init_ff;

   count_type  count_ff [NUM_SEMAPHORES];
   thread_type head_ff  [NUM_SEMAPHORES];
   thread_type tail_ff  [NUM_SEMAPHORES];
   thread_type next_ff  [NUM_THREADS];

   logic [RSP_W-1:0] rsp_ff;

   count_type  c_rd, c_wr;
   thread_type head_rd, tail_rd, succ_rd;
   logic       count_we, head_we, tail_we, next_we;
   thread_type head_wd;
   logic       blocked, wvalid, ovf;
   thread_type wthread;
   logic [RSP_W-1:0] rsp_in;

   assign c_rd    = count_ff[sem_ff];
   assign head_rd = head_ff[sem_ff];
   assign tail_rd = tail_ff[sem_ff];
   assign succ_rd = next_ff[head_rd];

   always_comb begin
      c_wr     = c_rd;
      count_we = 1'b0;
      head_we  = 1'b0;
      head_wd  = thread_ff;
      tail_we  = 1'b0;
      next_we  = 1'b0;
      blocked  = 1'b0;
      wvalid   = 1'b0;
      wthread  = '0;
      ovf      = 1'b0;
      case (opcode_ff)
         OP_WAIT: begin
            if (c_rd != COUNT_MIN) begin
               c_wr     = c_rd - 16'sd1;
               count_we = 1'b1;
               if (c_rd <= 16'sd0) begin
                  // caller joins the tail; an empty list takes it as head
                  blocked = 1'b1;
                  tail_we = 1'b1;
                  if (c_rd == 16'sd0) begin
                     head_we = 1'b1;
                  end else begin
                     next_we = 1'b1;
                  end
               end
            end
         end
         OP_SIGNAL: begin
            if (c_rd == COUNT_MAX) begin
               ovf = 1'b1;
            end else begin
               c_wr     = c_rd + 16'sd1;
               count_we = 1'b1;
               if (c_rd < 16'sd0) begin
                  wvalid  = 1'b1;
                  wthread = head_rd;
                  // successor is only valid when more waiters remain
                  if (c_rd < -16'sd1) begin
                     head_we = 1'b1;
                     head_wd = succ_rd;
                  end
               end
            end
         end
         OP_RELOAD: begin
            c_wr     = count_type'({1'b0, init_ff});
            count_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in = '0;
      rsp_in[RSP_FIELDS_W-1:0] = {ovf, c_wr, wthread, wvalid, blocked};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= INIT_RESET;
         count_ff <= '{default: '0};
      end else begin
         if (csr_valid) begin
            init_ff <= csr_data;
         end
         if (cmd.execute && count_we) begin
            count_ff[sem_ff] <= c_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= req_tdata[OP_W-1:0];
         sem_ff    <= req_tdata[OP_W +: SEM_W];
         thread_ff <= req_tdata[OP_W+SEM_W +: THREAD_W];
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
         if (head_we) begin
            head_ff[sem_ff] <= head_wd;
         end
         if (tail_we) begin
            tail_ff[sem_ff] <= thread_ff;
         end
         for (int i = 0; i < NUM_THREADS; i++) begin
            if (tail_we && (thread_type'(i) == thread_ff)) begin
               // a newly queued thread has no successor yet, even if it was the tail
               next_ff[i] <= '0;
            end else if (next_we && (thread_type'(i) == tail_rd)) begin
               next_ff[i] <= thread_ff;
            end
         end
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

### design/counting_semaphore_wait_queue.sv
// Bank of counting semaphores with FIFO wait lists.
//
// Channels: req (stream in) carries one operation per transaction:
// wait, signal or reload on one semaphore, with the caller's thread id.
// rsp (stream out) returns exactly one result transaction per request:
// caller blocked, woken thread, count after the operation, overflow.
// csr is a write-only port for the reload count; csr_ready is always
// high, and writes are expected only while the block is idle.
//
// Flow: an accepted request is captured into the request registers; the
// read-modify-write state on the count, head/tail and next-waiter tables
// then loads the result into the response register, and the next request
// is taken only after the controller has returned to idle.
// One request is in flight at a time; a new request is taken while the
// previous result is being handed off.
// Reset: all counts zero, reload count 1, no result pending. The wait
// lists are not cleared and are only read once written.
// A stalled rsp holds its result; req_tready stays low until it drains.
// Depends on cswq_pkg, cswq_ctrl and cswq_dp.
module counting_semaphore_wait_queue (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: opcode[1:0], sem_index[4:2], thread_id[8:5], zero fill
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cswq_pkg::REQ_W-1:0]  req_tdata,
   // rsp_tdata: caller_blocked[0], woken_valid[1], woken_thread[5:2],
   //            count_after[21:6], count_overflow[22], zero fill
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cswq_pkg::RSP_W-1:0]  rsp_tdata,
   // initial_count write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cswq_pkg::INIT_W-1:0] csr_data
);
   import cswq_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   cswq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cswq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##2 rsp_tvalid)
      else $error("no result two cycles after request");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !rsp_tvalid)
      else $error("execute while response slot still occupied");

   a_block_xor_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result both blocks caller and wakes a thread");
`endif

endmodule
